>>> hw/rtl/led_blink_sequencer_core_macros.svh
// assertion macros for the led blink sequencer core
`ifndef LED_BLINK_SEQUENCER_CORE_MACROS_SVH
`define LED_BLINK_SEQUENCER_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define LBS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define LBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/lbs_pkg.sv
// package with types and codes of the led blink sequencer
`default_nettype none
package lbs_pkg;

    localparam int PIN_W = 2;

    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_SET   = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    localparam logic [2:0] MODE_NONE  = 3'd0;
    localparam logic [2:0] MODE_OFF   = 3'd1;
    localparam logic [2:0] MODE_ON    = 3'd2;
    localparam logic [2:0] MODE_FLASH = 3'd3;
    localparam logic [2:0] MODE_BLINK = 3'd4;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] led_index;
        logic [2:0] led_mode;
        logic [7:0] on_ticks;
        logic [7:0] off_ticks;
        logic [7:0] repeat_count;
    } lbs_in_t;

    typedef struct packed {
        logic [PIN_W-1:0] pin_levels;
        logic [2:0]       selected_mode;
        logic             selected_busy;
    } lbs_out_t;

    // command from the top level to one led lane
    typedef struct packed {
        logic       tick;
        logic       set;
        logic [2:0] mode;
        logic [7:0] on_ticks;
        logic [7:0] off_ticks;
        logic [7:0] repeat_count;
    } lbs_ctrl_t;

    // lane status after this transfer's update
    typedef struct packed {
        logic       lit;
        logic [2:0] mode;
        logic       busy;
    } lbs_stat_t;

endpackage
`default_nettype wire

>>> hw/rtl/led_blink_sequencer_core.sv
// led blink sequencer top level: led lanes, result mux and output register
// a result is registered and appears in the cycle after its input transfer
// throughput: one request per cycle, set by the per-lane state update
// in_ready drops only while a finished result waits on a stalled output
// reset (rst_n, async, active low) clears all lane state: every led dark-mode none
// right after reset every pin reads 1 (dark) until a lamp is lit
`default_nettype none
module led_blink_sequencer_core #(
    parameter int LED_COUNT = 2
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire lbs_pkg::lbs_in_t  in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output lbs_pkg::lbs_out_t      out_data
);
    import lbs_pkg::*;

    `include "led_blink_sequencer_core_macros.svh"

    logic       accept;
    logic       is_tick;
    logic       is_set;
    lbs_ctrl_t  ctrl   [LED_COUNT];
    lbs_stat_t  stat   [LED_COUNT];
    logic [PIN_W-1:0] pins;
    lbs_out_t   res;
    logic       out_valid_reg, out_valid_next;
    lbs_out_t   out_data_reg, out_data_next;

    // the output register frees up in the same cycle it is read
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // req code 3 and query both leave the state alone
    assign is_tick = accept && (in_data.req_type == REQ_TICK);
    assign is_set  = accept && (in_data.req_type == REQ_SET) && (in_data.led_mode <= MODE_BLINK);

    // one lane per led, all updated in parallel on a tick
    for (genvar k = 0; k < LED_COUNT; k++)
    begin : g_lane
        assign ctrl[k].tick         = is_tick;
        assign ctrl[k].set          = is_set && (in_data.led_index == 8'(k));
        assign ctrl[k].mode         = in_data.led_mode;
        assign ctrl[k].on_ticks     = in_data.on_ticks;
        assign ctrl[k].off_ticks    = in_data.off_ticks;
        assign ctrl[k].repeat_count = in_data.repeat_count;

        lbs_led_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl[k]),
            .stat  (stat[k])
        );
    end

    // active-low pins; only the low PIN_W leds show, missing leds read 0
    for (genvar b = 0; b < PIN_W; b++)
    begin : g_pin
        if (b < LED_COUNT)
        begin : g_led
            assign pins[b] = ~stat[b].lit;
        end
        else
        begin : g_none
            assign pins[b] = 1'b0;
        end
    end

    // selected led fields; an out-of-range index selects nothing and gives zeros
    always_comb
    begin
        res.pin_levels    = pins;
        res.selected_mode = MODE_NONE;
        res.selected_busy = 1'b0;
        for (int k = 0; k < LED_COUNT; k++)
        begin
            if (in_data.led_index == 8'(k))
            begin
                res.selected_mode = stat[k].mode;
                res.selected_busy = stat[k].busy;
            end
        end
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res;
        end
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // every accepted request yields a result in the next cycle
    `LBS_ASSERT_NEXT(a_result_follows, clk, rst_n, accept, out_valid,
                     "result missing after transfer")
    // a waiting result is never overwritten
    `LBS_ASSERT_NOW(a_no_overwrite, clk, rst_n, out_valid && !out_ready, !in_ready,
                    "input taken over a stalled result")
    // lanes only ever report defined modes
    `LBS_ASSERT_NOW(a_mode_legal, clk, rst_n, out_valid, out_data.selected_mode <= MODE_BLINK,
                    "selected mode out of range")

endmodule
`default_nettype wire

>>> hw/rtl/lbs_led_lane.sv
// per-led state registers and their tick / set update
`default_nettype none
module lbs_led_lane (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lbs_pkg::lbs_ctrl_t ctrl,
    output lbs_pkg::lbs_stat_t     stat
);
    import lbs_pkg::*;

    logic [2:0] pend_mode_reg, pend_mode_next;
    logic [7:0] pend_on_reg, pend_on_next;
    logic [7:0] pend_off_reg, pend_off_next;
    logic [7:0] pend_rep_reg, pend_rep_next;
    logic [2:0] act_mode_reg, act_mode_next;
    logic [7:0] act_on_reg, act_on_next;
    logic [7:0] act_off_reg, act_off_next;
    logic [7:0] cyc_reg, cyc_next;
    logic [7:0] timer_reg, timer_next;
    logic       lit_reg, lit_next;
    logic       on_ph_reg, on_ph_next;
    logic       hold_reg, hold_next;
    logic       run_reg, run_next;
    logic [7:0] cyc_dec;

    assign cyc_dec = cyc_reg - 8'd1;

    always_comb
    begin
        pend_mode_next = pend_mode_reg;
        pend_on_next   = pend_on_reg;
        pend_off_next  = pend_off_reg;
        pend_rep_next  = pend_rep_reg;
        act_mode_next  = act_mode_reg;
        act_on_next    = act_on_reg;
        act_off_next   = act_off_reg;
        cyc_next       = cyc_reg;
        timer_next     = timer_reg;
        lit_next       = lit_reg;
        on_ph_next     = on_ph_reg;
        hold_next      = hold_reg;
        run_next       = run_reg;

        if (ctrl.tick)
        begin
            if (pend_mode_reg != MODE_NONE && !hold_reg)
            begin
                // take over the pending command
                act_mode_next  = pend_mode_reg;
                act_on_next    = pend_on_reg;
                act_off_next   = pend_off_reg;
                cyc_next       = pend_rep_reg;
                pend_mode_next = MODE_NONE;
                if (pend_mode_reg == MODE_ON || pend_mode_reg == MODE_OFF)
                begin
                    lit_next   = (pend_mode_reg == MODE_ON);
                    timer_next = 8'd0;
                    on_ph_next = 1'b0;
                    hold_next  = 1'b0;
                    run_next   = 1'b0;
                end
                else
                begin
                    lit_next   = 1'b1;
                    timer_next = pend_on_reg;
                    on_ph_next = 1'b1;
                    hold_next  = 1'b1;
                    run_next   = 1'b1;
                end
            end
            else
            begin
                if (act_mode_reg == MODE_FLASH || act_mode_reg == MODE_BLINK)
                begin
                    timer_next = timer_reg - 8'd1;
                    if (!on_ph_reg)
                        hold_next = 1'b0;
                    if (timer_next == 8'd0)
                    begin
                        if (on_ph_reg)
                        begin
                            lit_next   = ~lit_reg;
                            on_ph_next = 1'b0;
                            timer_next = (act_off_reg != 8'd0) ? act_off_reg : 8'd1;
                        end
                        else
                        begin
                            if (cyc_reg != 8'd0)
                            begin
                                cyc_next = cyc_dec;
                                if (cyc_dec == 8'd0)
                                begin
                                    act_mode_next = MODE_OFF;
                                    run_next      = 1'b0;
                                end
                            end
                            if (act_off_reg == 8'd0)
                            begin
                                act_mode_next = MODE_OFF;
                                run_next      = 1'b0;
                            end
                            else
                            begin
                                lit_next   = ~lit_reg;
                                on_ph_next = 1'b1;
                                timer_next = act_on_reg;
                            end
                        end
                    end
                end
                // steady modes force the lamp
                if (act_mode_next == MODE_ON)
                    lit_next = 1'b1;
                else if (act_mode_next == MODE_OFF)
                    lit_next = 1'b0;
            end
        end
        else if (ctrl.set)
        begin
            pend_mode_next = ctrl.mode;
            pend_on_next   = ctrl.on_ticks;
            pend_off_next  = ctrl.off_ticks;
            pend_rep_next  = ctrl.repeat_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_mode_reg <= MODE_NONE;
            pend_on_reg   <= '0;
            pend_off_reg  <= '0;
            pend_rep_reg  <= '0;
            act_mode_reg  <= MODE_NONE;
            act_on_reg    <= '0;
            act_off_reg   <= '0;
            cyc_reg       <= '0;
            timer_reg     <= '0;
            lit_reg       <= 1'b0;
            on_ph_reg     <= 1'b0;
            hold_reg      <= 1'b0;
            run_reg       <= 1'b0;
        end
        else
        begin
            pend_mode_reg <= pend_mode_next;
            pend_on_reg   <= pend_on_next;
            pend_off_reg  <= pend_off_next;
            pend_rep_reg  <= pend_rep_next;
            act_mode_reg  <= act_mode_next;
            act_on_reg    <= act_on_next;
            act_off_reg   <= act_off_next;
            cyc_reg       <= cyc_next;
            timer_reg     <= timer_next;
            lit_reg       <= lit_next;
            on_ph_reg     <= on_ph_next;
            hold_reg      <= hold_next;
            run_reg       <= run_next;
        end
    end

    // status reflects the state as it stands after this transfer
    assign stat.lit  = lit_next;
    assign stat.mode = act_mode_next;
    assign stat.busy = (pend_mode_next != MODE_NONE) || run_next;

endmodule
`default_nettype wire

>>> tb/tb.sv
// testbench for the led blink sequencer core: directed cases, random traffic, self-check
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import lbs_pkg::*;

    localparam int LEDS = 2;
    // no package names exist for these two codes, the block must still cope
    localparam logic [1:0] REQ_SPARE = 2'd3;
    localparam logic [2:0] MODE_SPARE = 3'd7;
    localparam int IDLE_LIMIT = 5000;
    localparam int REPORT_MAX = 10;

    // per-led copy of the block's state, kept by the predictor
    typedef struct {
        logic [2:0] pend_mode;
        logic [7:0] pend_on;
        logic [7:0] pend_off;
        logic [7:0] pend_rep;
        logic [2:0] act_mode;
        logic [7:0] act_on;
        logic [7:0] act_off;
        logic [7:0] rounds_left;
        logic [7:0] timer;
        logic       lit;
        logic       on_phase;
        logic       hold;
        logic       run;
    } lamp_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_ready;
    lbs_in_t  in_data = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    lbs_out_t out_data;

    lamp_t    lamps[LEDS];
    lbs_out_t status_due[$];

    bit traffic_calm = 1'b0;
    int mismatches = 0;
    int results_seen = 0;
    int ticks_sent = 0;
    int sets_sent = 0;
    int other_sent = 0;
    int idle_cycles = 0;
    int stall_left = 0;
    bit stall_level = 1'b1;

    led_blink_sequencer_core #(
        .LED_COUNT(LEDS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    function automatic void lamp_reset();
        for (int k = 0; k < LEDS; k++)
        begin
            lamps[k] = '{default: '0};
        end
    endfunction

    // pending command becomes the active one
    function automatic void lamp_load(int k);
        lamp_t ln;
        ln = lamps[k];
        ln.act_mode = ln.pend_mode;
        ln.act_on = ln.pend_on;
        ln.act_off = ln.pend_off;
        ln.rounds_left = ln.pend_rep;
        ln.pend_mode = MODE_NONE;
        if (ln.act_mode == MODE_ON || ln.act_mode == MODE_OFF)
        begin
            ln.lit = (ln.act_mode == MODE_ON);
            ln.timer = 8'd0;
            ln.on_phase = 1'b0;
            ln.hold = 1'b0;
            ln.run = 1'b0;
        end
        else
        begin
            ln.lit = 1'b1;
            ln.timer = ln.act_on;
            ln.on_phase = 1'b1;
            ln.hold = 1'b1;
            ln.run = 1'b1;
        end
        lamps[k] = ln;
    endfunction

    // one tick of a running sequence
    function automatic void lamp_advance(int k);
        lamp_t ln;
        ln = lamps[k];
        if (ln.act_mode == MODE_FLASH || ln.act_mode == MODE_BLINK)
        begin
            ln.timer = ln.timer - 8'd1;
            if (!ln.on_phase)
                ln.hold = 1'b0;
            if (ln.timer == 8'd0)
            begin
                if (ln.on_phase)
                begin
                    ln.lit = ~ln.lit;
                    ln.on_phase = 1'b0;
                    ln.timer = (ln.act_off != 8'd0) ? ln.act_off : 8'd1;
                end
                else
                begin
                    if (ln.rounds_left != 8'd0)
                    begin
                        ln.rounds_left = ln.rounds_left - 8'd1;
                        if (ln.rounds_left == 8'd0)
                        begin
                            ln.act_mode = MODE_OFF;
                            ln.run = 1'b0;
                        end
                    end
                    // zero off time: single flash, then done
                    if (ln.act_off == 8'd0)
                    begin
                        ln.act_mode = MODE_OFF;
                        ln.run = 1'b0;
                    end
                    else
                    begin
                        ln.lit = ~ln.lit;
                        ln.on_phase = 1'b1;
                        ln.timer = ln.act_on;
                    end
                end
            end
        end
        if (ln.act_mode == MODE_ON)
            ln.lit = 1'b1;
        else if (ln.act_mode == MODE_OFF)
            ln.lit = 1'b0;
        lamps[k] = ln;
    endfunction

    // updates the lamp copy for one request and returns the status it yields
    function automatic lbs_out_t predict_status(lbs_in_t item);
        lbs_out_t         res;
        logic [PIN_W-1:0] pins;
        int               idx;
        res = '0;
        pins = '0;
        idx = int'(item.led_index);
        if (item.req_type == REQ_TICK)
        begin
            for (int k = 0; k < LEDS; k++)
            begin
                if (lamps[k].pend_mode != MODE_NONE && !lamps[k].hold)
                    lamp_load(k);
                else
                    lamp_advance(k);
            end
        end
        else if (item.req_type == REQ_SET)
        begin
            if (idx < LEDS && item.led_mode <= MODE_BLINK)
            begin
                lamps[idx].pend_mode = item.led_mode;
                lamps[idx].pend_on = item.on_ticks;
                lamps[idx].pend_off = item.off_ticks;
                lamps[idx].pend_rep = item.repeat_count;
            end
        end
        for (int k = 0; k < LEDS; k++)
        begin
            if (!lamps[k].lit)
                pins[k] = 1'b1;
        end
        res.pin_levels = pins;
        if (idx < LEDS)
        begin
            res.selected_mode = lamps[idx].act_mode;
            res.selected_busy = (lamps[idx].pend_mode != MODE_NONE) || lamps[idx].run;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // monitor and checker: sample both channels at the edge
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        lbs_out_t want;
        if (rst_n)
        begin
            // results first, an input taken at this edge cannot have one yet
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (status_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: status transfer with nothing expected: %p",
                                 $realtime, out_data);
                end
                else
                begin
                    want = status_due.pop_front();
                    if (out_data.pin_levels !== want.pin_levels ||
                        out_data.selected_mode !== want.selected_mode ||
                        out_data.selected_busy !== want.selected_busy)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("%0t: exp pins %b mode %0d busy %b, got pins %b mode %0d busy %b",
                                     $realtime, want.pin_levels, want.selected_mode,
                                     want.selected_busy, out_data.pin_levels,
                                     out_data.selected_mode, out_data.selected_busy);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                status_due.push_back(predict_status(in_data));
                if (in_data.req_type == REQ_TICK)
                    ticks_sent++;
                else if (in_data.req_type == REQ_SET)
                    sets_sent++;
                else
                    other_sent++;
            end
        end
    end

    // watchdog: cycles in which no transfer happens on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                         IDLE_LIMIT, status_due.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // result side back-pressure: mostly ready, short stalls, a few long ones
    always @(posedge clk)
    begin
        if (traffic_calm)
        begin
            out_ready <= 1'b1;
        end
        else
        begin
            if (stall_left == 0)
            begin
                int r;
                r = $urandom_range(0, 99);
                if (r < 55)
                begin
                    stall_level = 1'b1;
                    stall_left = $urandom_range(1, 20);
                end
                else if (r < 90)
                begin
                    stall_level = 1'b0;
                    stall_left = $urandom_range(1, 3);
                end
                else
                begin
                    stall_level = 1'b0;
                    stall_left = $urandom_range(8, 40);
                end
            end
            else
            begin
                stall_left = stall_left - 1;
            end
            out_ready <= stall_level;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic int idle_gap();
        int r;
        if (traffic_calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic lbs_in_t make_req(logic [1:0] req, logic [7:0] idx, logic [2:0] mode,
                                         logic [7:0] on_t, logic [7:0] off_t,
                                         logic [7:0] rep);
        lbs_in_t item;
        item.req_type = req;
        item.led_index = idx;
        item.led_mode = mode;
        item.on_ticks = on_t;
        item.off_ticks = off_t;
        item.repeat_count = rep;
        return item;
    endfunction

    // drives one request and returns at the edge where it is taken
    task automatic send_item(input lbs_in_t item);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            in_data <= lbs_in_t'($bits(lbs_in_t)'({$urandom, $urandom}));
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // timers mostly short so sequences complete often
    function automatic logic [7:0] pick_ticks();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 8'($urandom_range(0, 4));
        else if (r < 95)
            return 8'($urandom_range(5, 20));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_repeat();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 8'd0;
        else if (r < 90)
            return 8'($urandom_range(1, 3));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [2:0] pick_mode();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return MODE_NONE;
        else if (r < 20)
            return MODE_OFF;
        else if (r < 32)
            return MODE_ON;
        else if (r < 66)
            return MODE_FLASH;
        return MODE_BLINK;
    endfunction

    // query index: mostly real leds, sometimes anything
    function automatic logic [7:0] pick_index();
        if ($urandom_range(0, 9) < 8)
            return 8'($urandom_range(0, LEDS - 1));
        return 8'($urandom_range(0, 255));
    endfunction

    // one random request; returns 0 for noise (dropped sets, spare code), 1 otherwise
    task automatic send_random(output bit counted);
        lbs_in_t item;
        int      r;
        item = lbs_in_t'($bits(lbs_in_t)'({$urandom, $urandom}));
        r = $urandom_range(0, 99);
        counted = 1'b1;
        if (r < 65)
        begin
            item.req_type = REQ_TICK;
            item.led_index = pick_index();
        end
        else if (r < 85)
        begin
            item = make_req(REQ_SET, 8'($urandom_range(0, LEDS - 1)), pick_mode(),
                            pick_ticks(), pick_ticks(), pick_repeat());
        end
        else if (r < 93)
        begin
            item.req_type = REQ_QUERY;
            item.led_index = pick_index();
        end
        else
        begin
            // noise: sets aimed at no led or with an unused mode, spare request code
            counted = 1'b0;
            case ($urandom_range(0, 2))
                0:
                begin
                    item.req_type = REQ_SET;
                    item.led_index = 8'($urandom_range(LEDS, 255));
                end
                1:
                begin
                    item.req_type = REQ_SET;
                    item.led_mode = 3'($urandom_range(MODE_BLINK + 1, MODE_SPARE));
                end
                default:
                begin
                    item.req_type = REQ_SPARE;
                    item.led_index = pick_index();
                end
            endcase
        end
        send_item(item);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset state seen through queries and a tick on idle leds
    task automatic test_after_reset();
        send_item(make_req(REQ_QUERY, 8'd0, MODE_NONE, 8'd0, 8'd0, 8'd0));
        send_item(make_req(REQ_QUERY, 8'd1, MODE_NONE, 8'd0, 8'd0, 8'd0));
        send_item(make_req(REQ_QUERY, 8'd255, MODE_NONE, 8'd0, 8'd0, 8'd0));
        send_item(make_req(REQ_TICK, 8'd0, MODE_NONE, 8'd0, 8'd0, 8'd0));
    endtask

    // sets that must be dropped, a clearing set, spare request code
    task automatic test_set_filtering();
        send_item(make_req(REQ_SET, 8'(LEDS), MODE_ON, 8'd255, 8'd255, 8'd255));
        send_item(make_req(REQ_SET, 8'd255, MODE_BLINK, 8'd255, 8'd255, 8'd255));
        send_item(make_req(REQ_SET, 8'd0, MODE_SPARE, 8'd255, 8'd0, 8'd255));
        send_item(make_req(REQ_SET, 8'd0, MODE_ON, 8'd0, 8'd0, 8'd0));
        send_item(make_req(REQ_SET, 8'd0, MODE_NONE, 8'd255, 8'd255, 8'd255));
        send_item(make_req(REQ_SPARE, 8'd0, MODE_SPARE, 8'd0, 8'd0, 8'd0));
        send_item(make_req(REQ_TICK, 8'd0, MODE_NONE, 8'd0, 8'd0, 8'd0));
    endtask

    // steady on and off
    task automatic test_steady_modes();
        send_item(make_req(REQ_SET, 8'd0, MODE_ON, 8'd3, 8'd3, 8'd0));
        send_item(make_req(REQ_SET, 8'd1, MODE_OFF, 8'd3, 8'd3, 8'd0));
        send_item(make_req(REQ_TICK, 8'd1, MODE_NONE, 8'd0, 8'd0, 8'd0));
        send_item(make_req(REQ_QUERY, 8'd0, MODE_NONE, 8'd0, 8'd0, 8'd0));
    endtask

    // single flash, counted blink, and a command held off by the first on phase
    task automatic test_single_flash();
        send_item(make_req(REQ_SET, 8'd0, MODE_FLASH, 8'd1, 8'd0, 8'd0));
        send_item(make_req(REQ_SET, 8'd1, MODE_BLINK, 8'd2, 8'd1, 8'd1));
        send_item(make_req(REQ_TICK, 8'd0, MODE_NONE, 8'd0, 8'd0, 8'd0));
        send_item(make_req(REQ_SET, 8'd1, MODE_ON, 8'd0, 8'd0, 8'd0));
        send_item(make_req(REQ_TICK, 8'd1, MODE_NONE, 8'd0, 8'd0, 8'd0));
        send_item(make_req(REQ_TICK, 8'd1, MODE_NONE, 8'd0, 8'd0, 8'd0));
        send_item(make_req(REQ_TICK, 8'd0, MODE_NONE, 8'd0, 8'd0, 8'd0));
        send_item(make_req(REQ_TICK, 8'd1, MODE_NONE, 8'd0, 8'd0, 8'd0));
        send_item(make_req(REQ_TICK, 8'd1, MODE_NONE, 8'd0, 8'd0, 8'd0));
        send_item(make_req(REQ_QUERY, 8'd0, MODE_NONE, 8'd0, 8'd0, 8'd0));
    endtask

    // zero on time wraps to a full 256-tick on phase; longest timers elsewhere
    task automatic test_timer_wrap();
        send_item(make_req(REQ_SET, 8'd0, MODE_BLINK, 8'd0, 8'd255, 8'd255));
        send_item(make_req(REQ_SET, 8'd1, MODE_FLASH, 8'd255, 8'd0, 8'd0));
        repeat (270)
        begin
            send_item(make_req(REQ_TICK, 8'($urandom_range(0, LEDS - 1)), MODE_NONE,
                               8'd0, 8'd0, 8'd0));
        end
    endtask

    // random traffic; n counts requests other than noise
    task automatic test_random_traffic(input int n);
        int done_cnt;
        bit counted;
        done_cnt = 0;
        while (done_cnt < n)
        begin
            send_random(counted);
            if (counted)
                done_cnt++;
        end
    endtask

    // no gaps on either side
    task automatic test_back_to_back(input int n);
        traffic_calm = 1'b1;
        test_random_traffic(n);
        traffic_calm = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin
        lamp_reset();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_after_reset();
        test_set_filtering();
        test_steady_modes();
        test_single_flash();
        test_timer_wrap();
        test_random_traffic(700);
        test_back_to_back(300);
        test_random_traffic(700);

        in_valid <= 1'b0;
        while (status_due.size() != 0)
            @(posedge clk);
        // spare idle cycles afterwards catch stray results
        repeat (8) @(posedge clk);

        $display("run covered %0d ticks, %0d set requests, %0d queries or spare codes",
                 ticks_sent, sets_sent, other_sent);
        $display("%0d status transfers compared, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0 && status_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
`default_nettype wire

>>> led_blink_sequencer_core.f
+incdir+hw/rtl
hw/rtl/lbs_pkg.sv
hw/rtl/lbs_led_lane.sv
hw/rtl/led_blink_sequencer_core.sv
tb/tb.sv
